// ===== hdl/ufbit_pkg.sv =====
// Package for the serial frame buffer: transaction types, event codes and register defaults.
package ufbit_pkg;

	// event codes carried in the kind field
	typedef enum logic [2:0] {
		KIND_RX_BYTE  = 3'd0,
		KIND_TICK     = 3'd1,
		KIND_TX_APPND = 3'd2,
		KIND_TX_READY = 3'd3,
		KIND_TX_DONE  = 3'd4,
		KIND_READ     = 3'd5,
		KIND_RELEASE  = 3'd6
	} kind_t;

	// register indexes (paddr bit 2)
	localparam logic REG_IDLE_TIMEOUT = 1'b0;
	localparam logic REG_ALIVE_RELOAD = 1'b1;

	localparam logic [7:0]  IDLE_DEFAULT  = 8'd5;
	localparam logic [15:0] ALIVE_DEFAULT = 16'd2000;
	localparam int          SHORT_LEN     = 8;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data_byte;
		logic       block_end;
		logic [5:0] entry_index;
	} item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       driver_enable;
		logic       tx_busy;
		logic       frame_ready;
		logic       short_frame;
		logic [5:0] rx_count;
		logic       link_alive;
		logic [7:0] read_data;
	} result_t;

endpackage

// ===== hdl/uart_frame_buffer_idle_timeout.sv =====
// Top level of the serial frame buffer with receive idle timeout and transmit queue.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+---------------------------------
//  item      | item_valid / item_ready  | item   (ufbit_pkg::item_t)
//  result    | result_valid/result_ready| result (ufbit_pkg::result_t)
//  config    | psel/penable/pwrite      | paddr, pwdata, prdata, pready=1
//
// One transaction per cycle while results are taken; each result appears in the cycle after
// its item is accepted, the byte store's registered read port lying between the two.
// The output register holds a result until taken; a new item is accepted in the same
// cycle the held result leaves, so a stalled result side stalls the item side.
// Reset clears the block state and loads the register defaults; store contents are undefined until written.
module uart_frame_buffer_idle_timeout #(
	parameter int BUF_SIZE = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             item_valid,
	output logic             item_ready,
	input  ufbit_pkg::item_t item,
	output logic             result_valid,
	input  logic             result_ready,
	output ufbit_pkg::result_t result
);
	import ufbit_pkg::*;

	localparam int AW = $clog2(BUF_SIZE);
	localparam int CW = $clog2(BUF_SIZE + 1);
	localparam int IW = (CW > 6) ? CW : 6;
	localparam int RW = (AW > 6) ? AW : 6;

	// configuration registers
	logic [7:0]  idle_cfg_q;
	logic [15:0] alive_cfg_q;
	logic        cfg_we;

	// block state
	logic [AW-1:0] rx_fill_q, rx_fill_d;
	logic [7:0]    idle_q, idle_d;
	logic [15:0]   alive_q, alive_d;
	logic          done_q, done_d;
	logic          short_q, short_d;
	logic          active_q, active_d;
	logic [CW-1:0] total_q, total_d;
	logic [CW-1:0] sent_q, sent_d;
	logic          drain_q, drain_d;

	// store access
	logic          st_we, st_re;
	logic [AW-1:0] st_waddr, st_raddr;
	logic [7:0]    st_rdata;

	// result stage
	logic          valid_s1;
	logic          txv_s1, rdsel_s1;
	logic          active_s1, done_s1, short_s1, alive_s1;
	logic [5:0]    count_s1;
	logic          txv, rdsel;
	logic          acc;
	logic [IW-1:0] idx_w;
	logic [RW-1:0] fill_w;

	assign pready     = 1'b1;
	assign cfg_we     = psel && penable && pwrite;
	assign item_ready = !valid_s1 || result_ready;
	assign acc        = item_valid && item_ready;
	assign idx_w      = IW'(item.entry_index);

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cfg_q  <= IDLE_DEFAULT;
			alive_cfg_q <= ALIVE_DEFAULT;
		end else if (cfg_we) begin
			if (paddr[2] == REG_IDLE_TIMEOUT) begin
				idle_cfg_q <= pwdata[7:0];
			end else begin
				alive_cfg_q <= pwdata[15:0];
			end
		end
	end

	// register read
	always_comb begin
		unique case (paddr[2])
			REG_IDLE_TIMEOUT: prdata = {24'd0, idle_cfg_q};
			REG_ALIVE_RELOAD: prdata = {16'd0, alive_cfg_q};
			default:          prdata = '0;
		endcase
	end

	// next state and store access for the accepted item
	always_comb begin
		rx_fill_d = rx_fill_q;
		idle_d    = idle_q;
		alive_d   = alive_q;
		done_d    = done_q;
		short_d   = short_q;
		active_d  = active_q;
		total_d   = total_q;
		sent_d    = sent_q;
		drain_d   = drain_q;
		st_we     = 1'b0;
		st_waddr  = rx_fill_q;
		st_re     = 1'b0;
		st_raddr  = '0;
		txv       = 1'b0;
		rdsel     = 1'b0;
		unique case (kind_t'(item.kind))
			KIND_RX_BYTE: begin
				alive_d = alive_cfg_q;
				if (!done_q) begin
					idle_d = idle_cfg_q;
					if (rx_fill_q < AW'(BUF_SIZE - 1)) begin
						st_we     = 1'b1;
						st_waddr  = rx_fill_q;
						rx_fill_d = rx_fill_q + 1'b1;
						if (rx_fill_d == AW'(SHORT_LEN)) begin
							short_d = 1'b1;
						end
						if (rx_fill_d == AW'(BUF_SIZE - 1)) begin
							done_d = 1'b1;
						end
					end
				end
			end
			KIND_TICK: begin
				if (idle_q != 8'd0) begin
					idle_d = idle_q - 8'd1;
					if ((idle_q == 8'd1) && (rx_fill_q != '0)) begin
						done_d = 1'b1;
					end
				end
				if (alive_q != 16'd0) begin
					alive_d = alive_q - 16'd1;
				end
			end
			KIND_TX_APPND: begin
				if (total_q < CW'(BUF_SIZE)) begin
					st_we    = 1'b1;
					st_waddr = total_q[AW-1:0];
					total_d  = total_q + 1'b1;
				end
				// block end while idle: send entry 0 at once
				if (!active_q && item.block_end) begin
					active_d = 1'b1;
					drain_d  = 1'b1;
					st_re    = 1'b1;
					st_raddr = '0;
					txv      = 1'b1;
					sent_d   = CW'(1);
				end
			end
			KIND_TX_READY: begin
				if (drain_q) begin
					if (sent_q < total_q) begin
						st_re    = 1'b1;
						st_raddr = sent_q[AW-1:0];
						txv      = 1'b1;
						sent_d   = sent_q + 1'b1;
					end else begin
						drain_d = 1'b0;
					end
				end
			end
			KIND_TX_DONE: begin
				if (active_q) begin
					active_d = 1'b0;
					drain_d  = 1'b0;
					total_d  = '0;
					sent_d   = '0;
				end
			end
			KIND_READ: begin
				if (idx_w < IW'(BUF_SIZE)) begin
					st_re    = 1'b1;
					st_raddr = idx_w[AW-1:0];
					rdsel    = 1'b1;
				end
			end
			KIND_RELEASE: begin
				rx_fill_d = '0;
				done_d    = 1'b0;
				short_d   = 1'b0;
				idle_d    = 8'd0;
			end
			default: begin
			end
		endcase
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_fill_q <= '0;
			idle_q    <= '0;
			alive_q   <= '0;
			done_q    <= 1'b0;
			short_q   <= 1'b0;
			active_q  <= 1'b0;
			total_q   <= '0;
			sent_q    <= '0;
			drain_q   <= 1'b0;
		end else if (acc) begin
			rx_fill_q <= rx_fill_d;
			idle_q    <= idle_d;
			alive_q   <= alive_d;
			done_q    <= done_d;
			short_q   <= short_d;
			active_q  <= active_d;
			total_q   <= total_d;
			sent_q    <= sent_d;
			drain_q   <= drain_d;
		end
	end

	ufbit_store #(
		.DEPTH(BUF_SIZE)
	) u_store (
		.clk  (clk),
		.we   (acc && st_we),
		.waddr(st_waddr),
		.wdata(item.data_byte),
		.re   (acc && st_re),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	assign fill_w = RW'(rx_fill_d);

	// output register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (result_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// output register: status and select flags
	always_ff @(posedge clk) begin
		if (acc) begin
			txv_s1    <= txv;
			rdsel_s1  <= rdsel;
			active_s1 <= active_d;
			done_s1   <= done_d;
			short_s1  <= short_d;
			count_s1  <= fill_w[5:0];
			alive_s1  <= (alive_d != 16'd0);
		end
	end

	assign result_valid         = valid_s1;
	assign result.tx_valid      = txv_s1;
	assign result.tx_byte       = txv_s1 ? st_rdata : 8'd0;
	assign result.driver_enable = active_s1;
	assign result.tx_busy       = active_s1;
	assign result.frame_ready   = done_s1;
	assign result.short_frame   = short_s1;
	assign result.rx_count      = count_s1;
	assign result.link_alive    = alive_s1;
	assign result.read_data     = rdsel_s1 ? st_rdata : 8'd0;

	// checks
	a_sent_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		sent_q <= total_q)
		else $error("sent count passed total");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(BUF_SIZE))
		else $error("transmit total beyond buffer size");

	a_drain_active: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> active_q)
		else $error("draining without active transmission");

	a_done_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rx_fill_q != '0))
		else $error("frame done with empty receive frame");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !result_ready) |-> !acc)
		else $error("item accepted while result held");

endmodule

// ===== hdl/ufbit_store.sv =====
// Shared byte store: one write port, one registered read port with write-first bypass.
module ufbit_store #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata
);
	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port; a write to the same entry in the same cycle is bypassed
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem[raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== dv/uart_frame_buffer_idle_timeout_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the serial frame buffer: directed events, then random traffic.

module uart_frame_buffer_idle_timeout_tb;
	import ufbit_pkg::*;

	localparam int         STORE_DEPTH = 64;
	localparam logic [2:0] KIND_UNUSED = 3'd7;

	// Tracks the buffer state, predicts each result and checks the results that come back
	class frame_scoreboard;
		logic [7:0]  store [STORE_DEPTH];
		bit          written [STORE_DEPTH];
		logic [5:0]  rx_fill;
		logic [7:0]  idle_timer;
		logic [15:0] alive_timer;
		bit          frame_done;
		bit          short_seen;
		bit          tx_active;
		bit          tx_draining;
		logic [6:0]  tx_total;
		logic [6:0]  tx_sent;
		logic [7:0]  idle_ticks;
		logic [15:0] alive_rel;
		result_t     pending_results [$];
		int          failures;
		int          noted;
		int          checked;

		function new();
			foreach (store[i]) begin
				store[i]   = '0;
				written[i] = 1'b0;
			end
			rx_fill     = '0;
			idle_timer  = '0;
			alive_timer = '0;
			frame_done  = 1'b0;
			short_seen  = 1'b0;
			tx_active   = 1'b0;
			tx_draining = 1'b0;
			tx_total    = '0;
			tx_sent     = '0;
			idle_ticks  = IDLE_DEFAULT;
			alive_rel   = ALIVE_DEFAULT;
			failures    = 0;
			noted       = 0;
			checked     = 0;
		endfunction

		function void write_reg(logic reg_idx, logic [31:0] value);
			if (reg_idx == REG_IDLE_TIMEOUT)
				idle_ticks = value[7:0];
			else
				alive_rel = value[15:0];
		endfunction

		function void note_failure(string msg);
			failures++;
			if (failures <= 10)
				$display("%0t ns: mismatch: %s", $time, msg);
		endfunction

		// random index among the entries written so far, -1 when there is none
		function int pick_written();
			int idx [$];
			foreach (written[i])
				if (written[i])
					idx.push_back(i);
			if (idx.size() == 0)
				return -1;
			return idx[$urandom_range(idx.size() - 1)];
		endfunction

		// apply one accepted event and queue the status it should produce
		function void take_item(item_t ev);
			result_t r;
			r = '0;
			case (ev.kind)
				KIND_RX_BYTE: begin
					alive_timer = alive_rel;
					// once a frame is done only the alive timer moves
					if (!frame_done) begin
						idle_timer = idle_ticks;
						if (rx_fill < STORE_DEPTH - 1) begin
							store[rx_fill]   = ev.data_byte;
							written[rx_fill] = 1'b1;
							rx_fill++;
							if (rx_fill == SHORT_LEN)
								short_seen = 1'b1;
							if (rx_fill == STORE_DEPTH - 1)
								frame_done = 1'b1;
						end
					end
				end
				KIND_TICK: begin
					if (idle_timer != 0) begin
						idle_timer--;
						if (idle_timer == 0 && rx_fill != 0)
							frame_done = 1'b1;
					end
					if (alive_timer != 0)
						alive_timer--;
				end
				KIND_TX_APPND: begin
					// appends beyond the store size are dropped
					if (tx_total < STORE_DEPTH) begin
						store[tx_total[5:0]]   = ev.data_byte;
						written[tx_total[5:0]] = 1'b1;
						tx_total++;
					end
					if (!tx_active && ev.block_end) begin
						tx_active   = 1'b1;
						tx_draining = 1'b1;
						tx_sent     = '0;
						if (tx_total != 0) begin
							r.tx_valid = 1'b1;
							r.tx_byte  = store[0];
							tx_sent    = 7'd1;
						end
					end
				end
				KIND_TX_READY: begin
					if (tx_draining) begin
						if (tx_sent < tx_total && tx_sent < STORE_DEPTH) begin
							r.tx_valid = 1'b1;
							r.tx_byte  = store[tx_sent[5:0]];
							tx_sent++;
						end else begin
							tx_draining = 1'b0;
						end
					end
				end
				KIND_TX_DONE: begin
					if (tx_active) begin
						tx_active   = 1'b0;
						tx_draining = 1'b0;
						tx_total    = '0;
						tx_sent     = '0;
					end
				end
				KIND_READ: r.read_data = store[ev.entry_index];
				KIND_RELEASE: begin
					rx_fill    = '0;
					frame_done = 1'b0;
					short_seen = 1'b0;
					idle_timer = '0;
				end
				default: ;
			endcase
			r.driver_enable = tx_active;
			r.tx_busy       = tx_active;
			r.frame_ready   = frame_done;
			r.short_frame   = short_seen;
			r.rx_count      = rx_fill;
			r.link_alive    = (alive_timer != 0);
			pending_results.push_back(r);
			noted++;
		endfunction

		function void check_result(result_t got);
			result_t exp;
			string   bad;
			checked++;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("result %h with nothing outstanding", got));
				return;
			end
			exp = pending_results.pop_front();
			bad = "";
			if (got.tx_valid !== exp.tx_valid)           bad = {bad, " tx_valid"};
			if (got.tx_byte !== exp.tx_byte)             bad = {bad, " tx_byte"};
			if (got.driver_enable !== exp.driver_enable) bad = {bad, " driver_enable"};
			if (got.tx_busy !== exp.tx_busy)             bad = {bad, " tx_busy"};
			if (got.frame_ready !== exp.frame_ready)     bad = {bad, " frame_ready"};
			if (got.short_frame !== exp.short_frame)     bad = {bad, " short_frame"};
			if (got.rx_count !== exp.rx_count)           bad = {bad, " rx_count"};
			if (got.link_alive !== exp.link_alive)       bad = {bad, " link_alive"};
			if (got.read_data !== exp.read_data)         bad = {bad, " read_data"};
			if (bad != "")
				note_failure($sformatf("result %0d,%s: expected %h, got %h",
					checked, bad, exp, got));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid;
	logic        item_ready;
	item_t       item;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;

	int gap_pct    = 0;
	int stall_pct  = 0;
	int hold_left  = 0;
	int hold_next  = 0;
	int sent_items = 0;
	int settings   = 0;

	frame_scoreboard sb;

	uart_frame_buffer_idle_timeout i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side: long hold-off when asked, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// every accepted result goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
	end

	// one event transaction; entered and left at a falling edge
	task automatic send_event(input item_t ev);
		if ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < gap_pct);
		end
		item       <= ev;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		sb.take_item(ev);
		sent_items++;
		if (hold_next > 0) begin
			hold_left = hold_next;
			hold_next = 0;
		end
		@(negedge clk);
	endtask

	function automatic item_t make_event(input logic [2:0] kind);
		item_t ev;
		ev.kind        = kind;
		ev.data_byte   = $urandom_range(255);
		ev.block_end   = $urandom_range(1);
		ev.entry_index = $urandom_range(63);
		return ev;
	endfunction

	task automatic send_op(input logic [2:0] kind, input logic [7:0] data, input logic last);
		item_t ev;
		ev           = make_event(kind);
		ev.data_byte = data;
		ev.block_end = last;
		send_event(ev);
	endtask

	// reads the given entry; idx < 0 picks a written entry at random, or sends a received byte if none is written
	task automatic send_read(input int idx);
		item_t ev;
		int    pick;
		pick = (idx < 0) ? sb.pick_written() : idx;
		if (pick < 0) begin
			ev = make_event(KIND_RX_BYTE);
		end else begin
			ev             = make_event(KIND_READ);
			ev.entry_index = pick[5:0];
		end
		send_event(ev);
	endtask

	// append a send block, pull bytes out with tx ready, optionally finish it
	task automatic tx_block(input int n, input int readies, input bit finish);
		for (int i = 0; i < n; i++)
			send_op(KIND_TX_APPND, $urandom_range(255), i == n - 1);
		repeat (readies)
			send_event(make_event(KIND_TX_READY));
		if (finish)
			send_event(make_event(KIND_TX_DONE));
	endtask

	task automatic hold_until_drained();
		item_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// APB write: setup then access; leaves the bus idle
	task automatic cfg_write(input logic reg_idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.write_reg(reg_idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// random mix of frames, timeouts, read-back and send blocks, with some noise
	task automatic random_traffic(input int n_items);
		int         target;
		int         r;
		int         len;
		logic [2:0] kind;
		target = sent_items + n_items;
		while (sent_items < target) begin
			r = $urandom_range(99);
			if (r < 25) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 12);
				repeat (len) send_event(make_event(KIND_RX_BYTE));
			end else if (r < 45) begin
				repeat ($urandom_range(1, 8)) send_event(make_event(KIND_TICK));
			end else if (r < 55) begin
				repeat ($urandom_range(1, 3)) send_read(-1);
			end else if (r < 63) begin
				send_event(make_event(KIND_RELEASE));
			end else if (r < 85) begin
				len = ($urandom_range(11) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
				tx_block(len, $urandom_range(0, len + 2), $urandom_range(4) != 0);
			end else begin
				repeat ($urandom_range(1, 4)) begin
					kind = $urandom_range(7);
					if (kind == KIND_READ)
						send_read(-1);
					else
						send_event(make_event(kind));
				end
			end
		end
	endtask

	initial begin
		sb         = new();
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		item_valid = 1'b0;
		item       = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: ignored events on an idle block, then a timed-out frame
		send_event(make_event(KIND_UNUSED));
		send_event(make_event(KIND_TX_READY));
		send_event(make_event(KIND_TX_DONE));
		send_event(make_event(KIND_RELEASE));
		send_op(KIND_RX_BYTE, 8'h00, 1'b0);
		send_op(KIND_RX_BYTE, 8'hff, 1'b1);
		send_read(0);
		send_read(1);
		repeat (IDLE_DEFAULT) send_event(make_event(KIND_TICK));
		// byte after the frame is done only keeps the link alive
		send_op(KIND_RX_BYTE, 8'h81, 1'b0);
		send_event(make_event(KIND_RELEASE));
		// send block, block end while active, drain to the end, append after draining
		send_op(KIND_TX_APPND, 8'ha5, 1'b0);
		send_op(KIND_TX_APPND, 8'h5a, 1'b1);
		send_op(KIND_TX_APPND, 8'h3c, 1'b1);
		repeat (3) send_event(make_event(KIND_TX_READY));
		send_op(KIND_TX_APPND, 8'h77, 1'b0);
		send_event(make_event(KIND_TX_READY));
		send_event(make_event(KIND_TX_DONE));
		send_read(3);

		// random phases, each with its own register setting and idling pattern
		for (int p = 0; p < 5; p++) begin
			hold_until_drained();
			case (p)
				0: begin
					cfg_write(REG_IDLE_TIMEOUT, 32'd255);
					cfg_write(REG_ALIVE_RELOAD, 32'd65535);
				end
				1: begin
					cfg_write(REG_IDLE_TIMEOUT, 32'd1);
					cfg_write(REG_ALIVE_RELOAD, 32'd0);
				end
				2: begin
					cfg_write(REG_IDLE_TIMEOUT, 32'd0);
					cfg_write(REG_ALIVE_RELOAD, 32'd3);
				end
				3: begin
					cfg_write(REG_IDLE_TIMEOUT, 32'd4);
					cfg_write(REG_ALIVE_RELOAD, 32'd20);
				end
				default: begin
					cfg_write(REG_IDLE_TIMEOUT, $urandom_range(1, 12));
					cfg_write(REG_ALIVE_RELOAD, $urandom_range(0, 40));
				end
			endcase
			settings++;
			gap_pct   = (p == 1) ? 64 : (p == 3) ? 23 : 0;
			stall_pct = (p == 2) ? 64 : (p == 3) ? 23 : 0;
			if (p == 0) begin
				// full receive frame, then a send block clipped at the store size
				send_event(make_event(KIND_RELEASE));
				repeat (66) send_event(make_event(KIND_RX_BYTE));
				send_read(STORE_DEPTH - 2);
				send_event(make_event(KIND_RELEASE));
				tx_block(66, 66, 1'b1);
				send_read(STORE_DEPTH - 1);
				// long result-side hold-off while events keep coming
				hold_next = 60;
				random_traffic(30);
			end else if (p == 1) begin
				random_traffic(35);
				hold_until_drained();
				random_traffic(35);
			end else begin
				random_traffic(70);
			end
		end

		hold_until_drained();
		repeat (10) @(posedge clk);
		if (sb.pending_results.size() != 0)
			sb.note_failure($sformatf("%0d results never arrived", sb.pending_results.size()));
		$display("Covered %0d events and %0d checked results over %0d register settings,",
			sb.noted, sb.checked, settings + 1);
		$display("with sender gaps, result stalls and a long result hold-off; %0d mismatches.",
			sb.failures);
		if (sb.failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#400000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
